/* sv/ash_pkg.sv */
// ----------------------------------------------------------------------------
// ash_pkg
// Shared types and constants of the AS space hash accumulator.
// ----------------------------------------------------------------------------
package ash_pkg;

    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // bits ahead of slot_index in the input tdata
    localparam int IN_FIXED_W = 94;
    // key, two sums and age count in the output tdata
    localparam int OUT_FIXED_W = 192;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'b001,
        KIND_READ = 3'b010,
        KIND_ZERO = 3'b100
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] key;
        logic [24:0] space_v4;
        logic [32:0] space_v6;
        logic [3:0]  age_index;
    } item_t;

endpackage

/* sv/ash_ram.sv */
// ----------------------------------------------------------------------------
// ash_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ash_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/ash_front.sv */
// ----------------------------------------------------------------------------
// ash_front
// Accepts items, classifies them and computes the home slot of a key.
// ----------------------------------------------------------------------------
module ash_front #(
    parameter int SLOT_W = 14,
    parameter int IN_W   = ((94 + SLOT_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic [IN_W-1:0]     s_tdata,
    output logic                push_valid,
    input  logic                push_ready,
    output ash_pkg::item_t      push_item,
    output logic [SLOT_W-1:0]   push_slot
);
    import ash_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MIX1 = 4'b0010,
        F_MIX2 = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t            state_reg, state_next;
    item_t              item_reg, item_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [31:0]        hash_reg, hash_next;
    logic [31:0]        in_key;
    logic [31:0]        mix_x;
    logic [31:0]        hash_fin;

    assign in_key   = s_tdata[31:0];
    assign mix_x    = hash_reg ^ (hash_reg >> 15);
    assign hash_fin = hash_reg ^ (hash_reg >> 16);

    assign s_tready   = (state_reg == F_IDLE) && enable;
    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = item_reg;
    assign push_slot  = (item_reg.kind == KIND_READ) ? slot_reg : hash_fin[SLOT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        slot_next  = slot_reg;
        hash_next  = hash_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    item_next.key       = in_key;
                    item_next.space_v4  = s_tdata[56:32];
                    item_next.space_v6  = s_tdata[89:57];
                    item_next.age_index = s_tdata[93:90];
                    slot_next           = s_tdata[IN_FIXED_W +: SLOT_W];
                    hash_next           = in_key ^ (in_key >> 16);
                    if (s_tuser)
                    begin
                        item_next.kind = KIND_READ;
                        state_next     = F_PUSH;
                    end
                    else if (in_key == 32'd0)
                    begin
                        item_next.kind = KIND_ZERO;
                        state_next     = F_PUSH;
                    end
                    else
                    begin
                        item_next.kind = KIND_ADD;
                        state_next     = F_MIX1;
                    end
                end
            end
            F_MIX1:
            begin
                hash_next  = hash_reg * HASH_MUL_A;
                state_next = F_MIX2;
            end
            F_MIX2:
            begin
                hash_next  = mix_x * HASH_MUL_B;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        hash_reg <= hash_next;
    end

endmodule

/* sv/ash_queue.sv */
// ----------------------------------------------------------------------------
// ash_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ash_queue #(
    parameter int DATA_W = 112
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/ash_back.sv */
// ----------------------------------------------------------------------------
// ash_back
// Probe engine: walks the table, updates or inserts, returns slot contents.
// ----------------------------------------------------------------------------
module ash_back #(
    parameter int TABLE_SLOTS = 16384,
    parameter int AGE_BUCKETS = 10,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int ENT_W       = SLOT_W + 1,
    parameter int OUT_W       = ((2 * SLOT_W + 1 + 192 + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    output logic               clear_done,
    input  logic               q_valid,
    output logic               q_ready,
    input  ash_pkg::item_t     q_item,
    input  logic [SLOT_W-1:0]  q_slot,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    output logic [1:0]         m_tuser
);
    import ash_pkg::*;

    localparam int ROW_W   = 160 + 32 * AGE_BUCKETS;
    localparam int LIMIT_W = ENT_W + 4;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT = LIMIT_W'(TABLE_SLOTS * 7);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_CHECK = 4'b1000
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic [ENT_W-1:0]   n_reg, n_next;
    logic               wrap_reg, wrap_next;
    item_t              item_reg, item_next;
    logic [ENT_W-1:0]   occ_reg, occ_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_addr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;

    logic [31:0]        rd_key;
    logic [63:0]        rd_v4, rd_v6, new_v4, new_v6;
    logic [32*AGE_BUCKETS-1:0] rd_lanes, new_lanes;
    logic [31:0]        rd_age, new_age;
    logic [ROW_W-1:0]   row_new;
    logic               is_match, is_empty, load_full, out_free;

    ash_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic logic [31:0] lane_pick(input logic [32*AGE_BUCKETS-1:0] lanes,
                                               input logic [3:0] age);
        logic [31:0] sel;
        sel = 32'd0;
        for (int i = 0; i < AGE_BUCKETS; i++)
        begin
            if (age == 4'(i))
            begin
                sel = lanes[32*i +: 32];
            end
        end
        return sel;
    endfunction

    assign rd_key   = ram_rdata[31:0];
    assign rd_v4    = ram_rdata[95:32];
    assign rd_v6    = ram_rdata[159:96];
    assign rd_lanes = ram_rdata[160 +: 32*AGE_BUCKETS];
    assign new_v4   = rd_v4 + 64'(item_reg.space_v4);
    assign new_v6   = rd_v6 + 64'(item_reg.space_v6);

    always_comb
    begin
        for (int i = 0; i < AGE_BUCKETS; i++)
        begin
            new_lanes[32*i +: 32] = rd_lanes[32*i +: 32]
                                  + 32'(item_reg.age_index == 4'(i));
        end
    end

    assign rd_age    = lane_pick(rd_lanes, item_reg.age_index);
    assign new_age   = lane_pick(new_lanes, item_reg.age_index);
    assign row_new   = {new_lanes, new_v6, new_v4, item_reg.key};
    assign is_match  = (rd_key == item_reg.key);
    assign is_empty  = (rd_key == 32'd0);
    // load check for one more occupied slot
    assign load_full = ((LIMIT_W'(occ_reg) + LIMIT_W'(1)) * LIMIT_W'(10)) >= LOAD_LIMIT;
    assign out_free  = !out_valid_reg || m_tready;

    assign clear_done = (state_reg != B_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser    = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        wrap_next      = wrap_reg;
        item_next      = item_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ram_we         = 1'b0;
        ram_wdata      = row_new;
        ram_addr       = (state_reg == B_CLEAR) ? clr_reg : pos_reg;
        q_ready        = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                clr_next  = clr_reg + SLOT_W'(1);
                if (clr_reg == {SLOT_W{1'b1}})
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == KIND_ZERO)
                    begin
                        if (out_free)
                        begin
                            q_ready        = 1'b1;
                            out_valid_next = 1'b1;
                            out_user_next  = ST_IGNORED;
                            out_data_next  = OUT_W'({occ_reg, 32'd0, 64'd0, 64'd0,
                                                     32'd0, SLOT_W'(0)});
                        end
                    end
                    else
                    begin
                        q_ready    = 1'b1;
                        item_next  = q_item;
                        pos_next   = q_slot;
                        n_next     = '0;
                        wrap_next  = 1'b0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (item_reg.kind == KIND_READ || wrap_reg ||
                    (is_empty && !is_match && load_full))
                begin
                    // plain slot contents: drain read or refused key
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_user_next  = (item_reg.kind == KIND_READ) ? ST_UPDATED : ST_FULL;
                        out_data_next  = OUT_W'({occ_reg, rd_age, rd_v6, rd_v4,
                                                 rd_key, pos_reg});
                        state_next     = B_IDLE;
                    end
                end
                else if (is_match || is_empty)
                begin
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        out_valid_next = 1'b1;
                        if (is_match)
                        begin
                            out_user_next = ST_UPDATED;
                            out_data_next = OUT_W'({occ_reg, new_age, new_v6, new_v4,
                                                    item_reg.key, pos_reg});
                        end
                        else
                        begin
                            occ_next      = occ_reg + ENT_W'(1);
                            out_user_next = ST_INSERTED;
                            out_data_next = OUT_W'({occ_reg + ENT_W'(1), new_age, new_v6,
                                                    new_v4, item_reg.key, pos_reg});
                        end
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    pos_next   = pos_reg + SLOT_W'(1);
                    n_next     = n_reg + ENT_W'(1);
                    // every slot tried: one more read of the home slot, then refuse
                    wrap_next  = (n_reg == ENT_W'(TABLE_SLOTS - 1));
                    state_next = B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        n_reg        <= n_next;
        wrap_reg     <= wrap_next;
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

/* sv/as_space_hash_accumulator.sv */
// ----------------------------------------------------------------------------
// as_space_hash_accumulator
// Keyed aggregation table of address space per AS, linear probing.
// ----------------------------------------------------------------------------
// an add's time from input to output grows with its probe steps; the probe
// loop reads the slots one at a time through the single table port
// the front takes a new item while the back is still busy with the last one,
// as long as the two-entry queue has room; each extra probe step lengthens
// the back's work on an item
// reset: asynchronous, then a clearing pass zeroes every table slot while
// s_tready stays low
module as_space_hash_accumulator #(
    parameter int TABLE_SLOTS = 16384,
    parameter int AGE_BUCKETS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tuser,                                       // cmd
    // as_number, space_v4, space_v6, age_index, slot_index
    input  logic [((94 + $clog2(TABLE_SLOTS) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [1:0] m_tuser,                                 // status
    // slot, key_out, total_v4, total_v6, age_count, entries_used
    output logic [((2 * $clog2(TABLE_SLOTS) + 1 + 192 + 7) / 8) * 8 - 1:0] m_tdata
);
    import ash_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int ENT_W  = SLOT_W + 1;
    localparam int IN_W   = ((IN_FIXED_W + SLOT_W + 7) / 8) * 8;
    localparam int OUT_W  = ((2 * SLOT_W + 1 + OUT_FIXED_W + 7) / 8) * 8;
    localparam int Q_W    = $bits(item_t) + SLOT_W;

    logic              clear_done;
    logic              f_valid, f_ready, q_valid, q_ready;
    item_t             f_item, q_item;
    logic [SLOT_W-1:0] f_slot, q_slot;
    logic [Q_W-1:0]    q_out;

    ash_front #(
        .SLOT_W (SLOT_W),
        .IN_W   (IN_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (clear_done),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .push_slot  (f_slot)
    );

    ash_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_slot, f_item}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    assign q_item = q_out[$bits(item_t)-1:0];
    assign q_slot = q_out[Q_W-1:$bits(item_t)];

    ash_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .AGE_BUCKETS (AGE_BUCKETS),
        .SLOT_W      (SLOT_W),
        .ENT_W       (ENT_W),
        .OUT_W       (OUT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .q_slot     (q_slot),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTH
    a_ignored_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_IGNORED) |-> (m_tdata[SLOT_W-1:0] == '0))
        else $error("ignored key reports a nonzero slot");

    a_insert_under_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_INSERTED) |->
        ((64'(m_tdata[SLOT_W + OUT_FIXED_W +: ENT_W]) * 64'd10)
            < (64'(TABLE_SLOTS) * 64'd7)))
        else $error("insert pushed load past the limit");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !s_tready)
        else $error("input taken during clearing pass");
`endif

endmodule
